[rtl/mlfs_pkg.sv]
// Package for the multilevel feedback scheduler: payload structs, codes, cell types.
// No dependencies.
package mlfs_pkg;

  localparam int unsigned MaxJobsDefault = 16;
  localparam int unsigned IdBitsDefault  = 16;
  localparam int unsigned WaitBits       = 6;
  localparam int unsigned CntBits        = 5;
  localparam int unsigned PayIdBits      = 16;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ENQ    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FINISH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_PRI  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOW_WAIT  = 2'd0,
    CFG_MID_WAIT  = 2'd1,
    CFG_MID_SLICE = 2'd2,
    CFG_LOW_SLICE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] job_number;
    logic [1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_id;
    logic        running_valid;
    logic [15:0] running_id;
    logic        switched;
    logic [4:0]  low_count;
    logic [4:0]  mid_count;
    logic [4:0]  high_count;
  } out_item_t;

  // Per-cycle command broadcast to every cell of one queue.
  typedef struct packed {
    logic        age;       // bump wait counters this cycle
    logic        shift;     // entries at and above shift_at take their upper neighbor
    logic        push;      // write push data at the tail
  } cell_ctl_t;

endpackage

[rtl/mlfs_cell.sv]
// One queue slot: id, wait and priority, shifting toward the head on removal.
// Depends on mlfs_pkg.
module mlfs_cell #(
  parameter int unsigned IdBits = 16
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [IdBits-1:0]          id_i,
  input  logic [mlfs_pkg::WaitBits-1:0] wait_i,
  input  logic [1:0]                 pri_i,
  input  logic                       age_i,
  output logic [IdBits-1:0]          id_o,
  output logic [mlfs_pkg::WaitBits-1:0] wait_o,
  output logic [1:0]                 pri_o
);
  import mlfs_pkg::*;

  logic [IdBits-1:0]   id_q;
  logic [WaitBits-1:0] wait_q;
  logic [1:0]          pri_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      id_q   <= id_i;
      wait_q <= wait_i;
      pri_q  <= pri_i;
    end else if (age_i && wait_q != {WaitBits{1'b1}}) begin
      wait_q <= wait_q + 1'b1;
    end
  end

  assign id_o   = id_q;
  assign wait_o = wait_q;
  assign pri_o  = pri_q;
endmodule

[rtl/mlfs_queue.sv]
// FIFO queue built as a row of slot cells; removal at any index shifts the upper cells down.
// Depends on mlfs_pkg, mlfs_cell.
module mlfs_queue #(
  parameter int unsigned MaxJobs = 16,
  parameter int unsigned IdBits  = 16,
  parameter int unsigned IdxBits = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlfs_pkg::cell_ctl_t         ctl_i,
  input  logic [IdxBits-1:0]          shift_at_i,
  input  logic [IdBits-1:0]           push_id_i,
  input  logic [1:0]                  push_pri_i,
  input  logic [IdxBits-1:0]          rd_idx_i,
  output logic [IdBits-1:0]           rd_id_o,
  output logic [mlfs_pkg::WaitBits-1:0] rd_wait_o,
  output logic [1:0]                  rd_pri_o,
  output logic [IdxBits:0]            len_o
);
  import mlfs_pkg::*;

  logic [IdBits-1:0]   id_w   [MaxJobs];
  logic [WaitBits-1:0] wait_w [MaxJobs];
  logic [1:0]          pri_w  [MaxJobs];
  logic [IdxBits:0]    len_q, len_d;

  // Push and shift never occur in the same cycle.
  always_comb begin
    len_d = len_q;
    if (ctl_i.shift && len_q != '0) len_d = len_q - 1'b1;
    else if (ctl_i.push && len_q != (IdxBits+1)'(MaxJobs)) len_d = len_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  for (genvar g = 0; g < MaxJobs; g++) begin : g_cell
    logic            ld;
    logic [IdBits-1:0]   nid;
    logic [WaitBits-1:0] nwait;
    logic [1:0]          npri;
    always_comb begin
      ld    = 1'b0;
      nid   = push_id_i;
      nwait = '0;
      npri  = push_pri_i;
      if (ctl_i.shift && (IdxBits+1)'(g) >= {1'b0, shift_at_i}) begin
        ld = (g + 1 < MaxJobs);
        if (g + 1 < MaxJobs) begin
          nid   = id_w[(g + 1) % MaxJobs];
          nwait = wait_w[(g + 1) % MaxJobs];
          npri  = pri_w[(g + 1) % MaxJobs];
        end
      end else if (ctl_i.push && len_q == (IdxBits+1)'(g)) begin
        ld = 1'b1;
      end
    end
    mlfs_cell #(.IdBits(IdBits)) u_cell (
      .clk_i (clk_i),
      .load_i(ld),
      .id_i  (nid),
      .wait_i(nwait),
      .pri_i (npri),
      .age_i (ctl_i.age && (IdxBits+1)'(g) >= {1'b0, shift_at_i}),
      .id_o  (id_w[g]),
      .wait_o(wait_w[g]),
      .pri_o (pri_w[g])
    );
  end

  assign rd_id_o   = id_w[rd_idx_i];
  assign rd_wait_o = wait_w[rd_idx_i];
  assign rd_pri_o  = pri_w[rd_idx_i];
  assign len_o     = len_q;
endmodule

[rtl/multilevel_feedback_scheduler.sv]
// Multilevel feedback scheduler: three job queues of slot cells and a control sequencer.
// A finish item goes straight to building its result; every other item first ages the mid
// then the low queue one slot a cycle, then enqueues or scans for a remove and may pick a job.
// One item at a time; the result waits in an output register while the next item may already
// be accepted, and a stalled output register holds the sequencer in S_HOLD.
// Asynchronous active-low reset empties all queues and clears the running slot and counters.
module multilevel_feedback_scheduler
  import mlfs_pkg::*;
#(
  parameter int unsigned MaxJobs = MaxJobsDefault,
  parameter int unsigned IdBits  = IdBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mlfs_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mlfs_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [5:0]           cfg_data_i
);
  localparam int unsigned IdxBits = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned LenBits = IdxBits + 1;

  // One-hot sequencer.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_AGE    = 9'b000000010, // age pass over current queue (mid then low)
    S_CMD    = 9'b000000100, // enqueue or start remove scan
    S_SCAN   = 9'b000001000, // remove: compare one slot a cycle
    S_PICK   = 9'b000010000, // choose queue and, when due, pop its head
    S_BACK   = 9'b000100000, // requeue preempted job
    S_OUT    = 9'b001000000, // build the result
    S_HOLD   = 9'b010000000, // result waits for a free output register
    S_AGE2   = 9'b100000000  // single-cycle aging bump before the walk
  } state_e;

  state_e state_q, state_d;

  logic [5:0] low_wait_q, mid_wait_q;
  logic [3:0] mid_slice_q, low_slice_q;

  in_item_t item_q;
  logic     out_valid_q;
  out_item_t out_q, res_d;

  logic              run_valid_q, run_done_q;
  logic [IdBits-1:0] run_id_q;
  logic [1:0]        run_pri_q;
  logic [IdBits-1:0] id_cnt_q;
  logic [3:0]        mid_ticks_q, low_ticks_q;

  logic [1:0]         status_q;
  logic [IdBits-1:0]  assigned_q;
  logic               switched_q;

  // Scan pointer and queue selector (0 low,1 mid,2 high).
  logic [1:0]         qsel_q;
  logic [LenBits-1:0] ptr_q;
  logic [IdBits-1:0]  back_id_q;
  logic [1:0]         back_pri_q;
  logic               back_pend_q;

  cell_ctl_t          ctl   [3];
  logic [IdxBits-1:0] sat   [3];
  logic [IdBits-1:0]  pid   [3];
  logic [1:0]         ppri  [3];
  logic [IdBits-1:0]  rid   [3];
  logic [WaitBits-1:0] rwait[3];
  logic [1:0]         rpri  [3];
  logic [LenBits-1:0] len   [3];

  for (genvar q = 0; q < 3; q++) begin : g_q
    mlfs_queue #(.MaxJobs(MaxJobs), .IdBits(IdBits), .IdxBits(IdxBits)) u_q (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[q]),
      .shift_at_i(sat[q]),
      .push_id_i (pid[q]),
      .push_pri_i(ppri[q]),
      .rd_idx_i  (ptr_q[IdxBits-1:0]),
      .rd_id_o   (rid[q]),
      .rd_wait_o (rwait[q]),
      .rd_pri_o  (rpri[q]),
      .len_o     (len[q])
    );
  end

  logic [LenBits+1:0] total;
  logic [IdBits-1:0]  id_next;
  logic [5:0]         thr;
  logic [WaitBits-1:0] cur_wait;
  logic [LenBits-1:0] cur_len;
  logic               ptr_in;

  assign total   = (LenBits+2)'(len[0]) + (LenBits+2)'(len[1]) + (LenBits+2)'(len[2])
                 + (LenBits+2)'(run_valid_q);
  assign id_next = (id_cnt_q + 1'b1 == '0) ? IdBits'(1) : id_cnt_q + 1'b1;
  assign thr     = (qsel_q == 2'd1) ? mid_wait_q : low_wait_q;
  assign cur_wait = rwait[qsel_q];
  assign cur_len = len[qsel_q];
  assign ptr_in  = ptr_q < cur_len;

  // Sequencer registers written in the control block below.
  logic [1:0]         status_d;
  logic [IdBits-1:0]  assigned_d, run_id_d, id_cnt_d, back_id_d;
  logic               switched_d, run_valid_d, run_done_d, back_pend_d;
  logic [1:0]         run_pri_d, qsel_d, back_pri_d;
  logic [LenBits-1:0] ptr_d;
  logic [3:0]         mid_ticks_d, low_ticks_d;
  logic               take;
  logic [1:0]         pick;
  logic               do_pick;
  logic [3:0]         mt, lt;

  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    assigned_d  = assigned_q;
    switched_d  = switched_q;
    run_valid_d = run_valid_q;
    run_done_d  = run_done_q;
    run_id_d    = run_id_q;
    run_pri_d   = run_pri_q;
    id_cnt_d    = id_cnt_q;
    qsel_d      = qsel_q;
    ptr_d       = ptr_q;
    mid_ticks_d = mid_ticks_q;
    low_ticks_d = low_ticks_q;
    back_id_d   = back_id_q;
    back_pri_d  = back_pri_q;
    back_pend_d = back_pend_q;
    pick        = 2'd0;
    do_pick     = 1'b0;
    mt          = mid_ticks_q + 1'b1;
    lt          = low_ticks_q + 1'b1;
    for (int k = 0; k < 3; k++) begin
      ctl[k]  = '0;
      sat[k]  = '0;
      pid[k]  = back_id_q;
      ppri[k] = back_pri_q;
    end
    res_d = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          status_d   = ST_OK;
          assigned_d = '0;
          switched_d = 1'b0;
          if (in_data_i.req_type == REQ_FINISH) begin
            if (run_valid_q) run_done_d = 1'b1;
            state_d = S_OUT;
          end else begin
            qsel_d  = 2'd1;
            state_d = S_AGE2;
          end
        end
      end
      S_AGE2: begin
        // Bump every wait in the selected queue, then walk from the head.
        ctl[qsel_q].age = 1'b1;
        ptr_d   = '0;
        state_d = S_AGE;
      end
      S_AGE: begin
        if (!ptr_in) begin
          if (qsel_q == 2'd1) begin
            qsel_d  = 2'd0;
            state_d = S_AGE2;
          end else begin
            state_d = S_CMD;
          end
        end else if (cur_wait >= thr) begin
          // Promote: unlink here, push on the next queue up with wait zero.
          ctl[qsel_q].shift = 1'b1;
          sat[qsel_q]       = ptr_q[IdxBits-1:0];
          ctl[qsel_q + 2'd1].push = 1'b1;
          pid[qsel_q + 2'd1]  = rid[qsel_q];
          ppri[qsel_q + 2'd1] = rpri[qsel_q];
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_CMD: begin
        ptr_d   = '0;
        qsel_d  = 2'd0;
        state_d = S_PICK;
        if (item_q.req_type == REQ_ENQ) begin
          if (item_q.priority_req == 2'd0) begin
            status_d = ST_BAD_PRI;
          end else if (total >= (LenBits+2)'(MaxJobs)) begin
            status_d = ST_FULL;
          end else begin
            id_cnt_d   = id_next;
            assigned_d = id_next;
            ctl[item_q.priority_req - 2'd1].push = 1'b1;
            pid[item_q.priority_req - 2'd1]  = id_next;
            ppri[item_q.priority_req - 2'd1] = item_q.priority_req;
          end
        end else if (item_q.req_type == REQ_REMOVE) begin
          if (run_valid_q && run_id_q == IdBits'(item_q.job_number)) begin
            run_valid_d = 1'b0;
            run_done_d  = 1'b0;
            run_id_d    = '0;
            run_pri_d   = '0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!ptr_in) begin
          ptr_d = '0;
          if (qsel_q == 2'd2) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_PICK;
          end else begin
            qsel_d = qsel_q + 2'd1;
          end
        end else if (rid[qsel_q] == IdBits'(item_q.job_number)) begin
          ctl[qsel_q].shift = 1'b1;
          sat[qsel_q]       = ptr_q[IdxBits-1:0];
          ptr_d   = '0;
          state_d = S_PICK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_PICK: begin
        ptr_d   = '0;
        state_d = S_OUT;
        if (len[2] != '0) begin
          pick = 2'd2; do_pick = 1'b1;
        end else if (len[1] != '0) begin
          mid_ticks_d = mt;
          if (mt >= mid_slice_q) begin
            mid_ticks_d = '0; pick = 2'd1; do_pick = 1'b1;
          end
        end else if (len[0] != '0) begin
          low_ticks_d = lt;
          if (lt >= low_slice_q) begin
            low_ticks_d = '0; pick = 2'd0; do_pick = 1'b1;
          end
        end
        if (do_pick) begin
          // ptr_q is zero here, so rid reads the head of each queue.
          ctl[pick].shift = 1'b1;
          switched_d  = 1'b1;
          back_pend_d = run_valid_q && !run_done_q && run_pri_q != 2'd0;
          back_id_d   = run_id_q;
          back_pri_d  = run_pri_q;
          run_id_d    = rid[pick];
          run_pri_d   = rpri[pick];
          run_valid_d = 1'b1;
          run_done_d  = 1'b0;
          state_d     = S_BACK;
        end
      end
      S_BACK: begin
        if (back_pend_q) ctl[back_pri_q - 2'd1].push = 1'b1;
        back_pend_d = 1'b0;
        state_d     = S_OUT;
      end
      S_OUT: begin
        res_d.status        = status_q;
        res_d.assigned_id   = PayIdBits'(assigned_q);
        res_d.running_valid = run_valid_q && !run_done_q;
        res_d.running_id    = (run_valid_q && !run_done_q) ? PayIdBits'(run_id_q) : '0;
        res_d.switched      = switched_q;
        res_d.low_count     = CntBits'(len[0]);
        res_d.mid_count     = CntBits'(len[1]);
        res_d.high_count    = CntBits'(len[2]);
        state_d = (out_valid_q && !out_ready_i) ? S_HOLD : S_IDLE;
        if (out_valid_q && !out_ready_i) res_d = out_q;
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      run_valid_q <= 1'b0;
      run_done_q  <= 1'b0;
      run_id_q    <= '0;
      run_pri_q   <= '0;
      id_cnt_q    <= '0;
      mid_ticks_q <= '0;
      low_ticks_q <= '0;
      back_pend_q <= 1'b0;
      low_wait_q  <= 6'd10;
      mid_wait_q  <= 6'd5;
      mid_slice_q <= 4'd2;
      low_slice_q <= 4'd5;
    end else begin
      state_q     <= state_d;
      run_valid_q <= run_valid_d;
      run_done_q  <= run_done_d;
      run_id_q    <= run_id_d;
      run_pri_q   <= run_pri_d;
      id_cnt_q    <= id_cnt_d;
      mid_ticks_q <= mid_ticks_d;
      low_ticks_q <= low_ticks_d;
      back_pend_q <= back_pend_d;
      if (state_q == S_OUT && !(out_valid_q && !out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LOW_WAIT:  low_wait_q  <= cfg_data_i;
          CFG_MID_WAIT:  mid_wait_q  <= cfg_data_i;
          CFG_MID_SLICE: mid_slice_q <= cfg_data_i[3:0];
          CFG_LOW_SLICE: low_slice_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= in_data_i;
    status_q   <= status_d;
    assigned_q <= assigned_d;
    switched_q <= switched_d;
    qsel_q     <= qsel_d;
    ptr_q      <= ptr_d;
    back_id_q  <= back_id_d;
    back_pri_q <= back_pri_d;
    out_q      <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_done_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done_q |-> run_valid_q) else $error("done without running job");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_back_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BACK) |-> $past(state_q == S_PICK)) else $error("requeue out of order");
`endif
endmodule

[tb/sv/testbench.sv]
// Testbench for multilevel_feedback_scheduler: drives items, config writes, and checks
// every result against an in-file scheduler predictor. Depends on rtl/mlfs_pkg.sv and the RTL.
`timescale 1ns / 1ps

module testbench;
  import mlfs_pkg::*;

  localparam int unsigned MaxJobs = 16;
  localparam int unsigned CycleLimit = 2000000;

  // Waiting job as the predictor sees it.
  typedef struct {
    logic [15:0] id;
    int unsigned wait_cnt;
    int unsigned pri;
  } job_t;

  // Scheduler predictor plus the queue of predicted results.
  class sched_scoreboard;
    job_t         lvl_q[3][$];
    bit           run_vld;
    bit           run_fin;
    job_t         run_job;
    logic [15:0]  next_id;
    int unsigned  mid_tk, low_tk;
    int unsigned  low_wait, mid_wait, mid_sl, low_sl;
    out_item_t    pending[$];
    int unsigned  errors;
    int unsigned  checked;

    function void clear();
      for (int k = 0; k < 3; k++) lvl_q[k].delete();
      run_vld = 0; run_fin = 0; run_job = '{0, 0, 0};
      next_id = 0; mid_tk = 0; low_tk = 0;
      low_wait = 10; mid_wait = 5; mid_sl = 2; low_sl = 5;
      pending.delete();
      errors = 0; checked = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [5:0] val);
      case (idx)
        CFG_LOW_WAIT:  low_wait = val;
        CFG_MID_WAIT:  mid_wait = val;
        CFG_MID_SLICE: mid_sl = val[3:0];
        default:       low_sl = val[3:0];
      endcase
    endfunction

    function int unsigned total_jobs();
      return lvl_q[0].size() + lvl_q[1].size() + lvl_q[2].size() + run_vld;
    endfunction

    // Age one queue; jobs that reached the threshold move to dest tail if it has room.
    function void age_level(int k, int unsigned thresh, int dest);
      job_t j;
      int i;
      i = 0;
      while (i < lvl_q[k].size()) begin
        if (lvl_q[k][i].wait_cnt < 63) lvl_q[k][i].wait_cnt++;
        if (lvl_q[k][i].wait_cnt >= thresh) begin
          j = lvl_q[k][i];
          lvl_q[k].delete(i);
          j.wait_cnt = 0;
          if (lvl_q[dest].size() < MaxJobs) lvl_q[dest].push_back(j);
        end else begin
          i++;
        end
      end
    endfunction

    function bit drop_id(logic [15:0] id);
      if (run_vld && run_job.id == id) begin
        run_vld = 0; run_fin = 0; run_job = '{0, 0, 0};
        return 1;
      end
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < lvl_q[k].size(); i++)
          if (lvl_q[k][i].id == id) begin
            lvl_q[k].delete(i);
            return 1;
          end
      return 0;
    endfunction

    function void pick(int k);
      job_t nxt, back;
      nxt = lvl_q[k].pop_front();
      if (run_vld && run_fin) begin
        run_vld = 0; run_fin = 0;
      end
      if (run_vld) begin
        back = run_job;
        back.wait_cnt = 0;
        if (back.pri >= 1 && back.pri <= 3 && lvl_q[back.pri-1].size() < MaxJobs)
          lvl_q[back.pri-1].push_back(back);
      end
      nxt.wait_cnt = 0;
      run_job = nxt; run_vld = 1; run_fin = 0;
    endfunction

    // Note an accepted input item and queue its predicted result.
    function void note_item(in_item_t it);
      out_item_t r;
      job_t j;
      r = '0;
      if (it.req_type == REQ_FINISH) begin
        if (run_vld) run_fin = 1;
      end else begin
        age_level(1, mid_wait, 2);
        age_level(0, low_wait, 1);
        if (it.req_type == REQ_ENQ) begin
          if (it.priority_req == 0) r.status = ST_BAD_PRI;
          else if (total_jobs() >= MaxJobs) r.status = ST_FULL;
          else begin
            next_id = next_id + 16'd1;
            if (next_id == 0) next_id = 1;
            j = '{next_id, 0, it.priority_req};
            lvl_q[it.priority_req-1].push_back(j);
            r.assigned_id = next_id;
          end
        end else if (it.req_type == REQ_REMOVE) begin
          if (!drop_id(it.job_number)) r.status = ST_NOT_FOUND;
        end
        if (lvl_q[2].size() > 0) begin
          pick(2); r.switched = 1;
        end else if (lvl_q[1].size() > 0) begin
          mid_tk = (mid_tk + 1) & 15;
          if (mid_tk >= mid_sl) begin
            mid_tk = 0; pick(1); r.switched = 1;
          end
        end else if (lvl_q[0].size() > 0) begin
          low_tk = (low_tk + 1) & 15;
          if (low_tk >= low_sl) begin
            low_tk = 0; pick(0); r.switched = 1;
          end
        end
      end
      r.running_valid = run_vld && !run_fin;
      r.running_id = r.running_valid ? run_job.id : 16'd0;
      r.low_count = 5'(lvl_q[0].size());
      r.mid_count = 5'(lvl_q[1].size());
      r.high_count = 5'(lvl_q[2].size());
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [5:0] cfg_data_i = '0;

  sched_scoreboard sb;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  bit          calm = 0;  // no idling on either side during this stretch

  multilevel_feedback_scheduler u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: the cycle limit leaves ample room for the slowest tick and for stalls.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout", $realtime);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall on ready, check every transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      out_ready_i <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Valid drops only on an idle cycle or in drain, so back-to-back items keep it high.
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send(req_e rq, logic [15:0] num, logic [1:0] pri);
    in_item_t it;
    it.req_type = rq;
    it.job_number = num;
    it.priority_req = pri;
    send_item(it);
  endtask

  // Wait until all results are in and the block has had time to finish its work.
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [5:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [5:0] lw, logic [5:0] mw, logic [5:0] ms, logic [5:0] ls);
    drain();
    write_cfg(CFG_LOW_WAIT, lw);
    write_cfg(CFG_MID_WAIT, mw);
    write_cfg(CFG_MID_SLICE, ms);
    write_cfg(CFG_LOW_SLICE, ls);
  endtask

  // Mostly enqueues and ticks, removes mostly aimed at recent ids, some finishes and noise.
  task automatic random_item();
    int unsigned sel;
    logic [15:0] num;
    sel = $urandom_range(99);
    num = 16'($urandom);
    if (sel < 35) send(REQ_ENQ, 16'($urandom), 2'($urandom_range(1, 3)));
    else if (sel < 38) send(REQ_ENQ, 16'($urandom), 2'd0);
    else if (sel < 60) send(REQ_TICK, 16'($urandom), 2'($urandom));
    else if (sel < 78) begin
      if ($urandom_range(3) != 0 && sb.next_id != 0)
        num = 16'(sb.next_id - $urandom_range(0, 20));
      send(REQ_REMOVE, num, 2'($urandom));
    end else send(REQ_FINISH, 16'($urandom), 2'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: bad priority, each priority, finish, removes hit and miss, fill to full.
    calm = 1;
    send(REQ_TICK, 16'hffff, 2'd3);
    send(REQ_FINISH, 16'h0, 2'd0);
    send(REQ_ENQ, 16'h0, 2'd0);
    send(REQ_ENQ, 16'hffff, 2'd1);
    send(REQ_ENQ, 16'h0, 2'd2);
    send(REQ_ENQ, 16'h0, 2'd3);
    send(REQ_FINISH, 16'h0, 2'd0);
    send(REQ_TICK, 16'h0, 2'd0);
    send(REQ_REMOVE, 16'd2, 2'd0);
    send(REQ_REMOVE, 16'hffff, 2'd3);
    for (int i = 0; i < 18; i++) send(REQ_ENQ, 16'h0, 2'(1 + i % 3));
    calm = 0;

    // Reset values first, then extremes and random settings, including zero.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: ;
        1: set_all(6'd1, 6'd1, 6'd1, 6'd1);
        2: set_all(6'd63, 6'd63, 6'd15, 6'd15);
        3: set_all(6'd0, 6'd0, 6'd0, 6'd0);
        default: set_all(6'($urandom_range(1, 20)), 6'($urandom_range(1, 20)),
                         6'($urandom_range(1, 6)), 6'($urandom_range(1, 8)));
      endcase
      calm = (ph == 4);
      repeat (60) random_item();
    end
    calm = 0;
    drain();

    $display("Covered %0d items, %0d results checked, config extremes and random settings.",
             items_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
